FILE: rtl/tbp_pkg.sv
// Shared constants, types and helpers for the tournament branch predictor.
`timescale 1ns / 1ps
package tbp_pkg;
  localparam int INDEX_BITS       = 15;
  localparam int MAX_COUNTER_BITS = 8;
  localparam int ENTRIES          = 1 << INDEX_BITS;
  localparam int ADDR_BITS        = 32;
  localparam int CFG_BITS         = 4;
  localparam int CHOOSE_BITS      = 2;
  localparam int QUEUE_DEPTH      = 2;

  typedef logic [INDEX_BITS-1:0]       idx_t;
  typedef logic [MAX_COUNTER_BITS-1:0] ctr_t;
  typedef logic [CHOOSE_BITS-1:0]      chs_t;
  typedef logic [CFG_BITS-1:0]         cfg_t;

  localparam chs_t CHS_MAX = '1;
  localparam chs_t CHS_GSHARE = chs_t'(2);

  typedef struct packed {
    idx_t pc;
    logic taken;
  } item_t;

  // queue head as seen by the back end
  typedef struct packed {
    logic  valid;
    item_t item;
  } head_t;

  // back end status toward the front
  typedef struct packed {
    logic pop;
    logic clearing;
  } back_stat_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_HIST,
    ST_CALC
  } back_state_t;

  function automatic cfg_t eff_bits(input cfg_t b);
    cfg_t r;
    r = b;
    if (r < cfg_t'(1)) r = cfg_t'(1);
    if (r > cfg_t'(MAX_COUNTER_BITS)) r = cfg_t'(MAX_COUNTER_BITS);
    return r;
  endfunction

  function automatic ctr_t max_val(input cfg_t bits);
    logic [MAX_COUNTER_BITS:0] one;
    one = (MAX_COUNTER_BITS+1)'(1) << bits;
    return ctr_t'(one - (MAX_COUNTER_BITS+1)'(1));
  endfunction

  function automatic ctr_t bump(input ctr_t c, input ctr_t maxv, input logic up);
    ctr_t r;
    r = c;
    if (up) begin
      if (c < maxv) r = c + ctr_t'(1);
    end else begin
      if (c != '0) r = c - ctr_t'(1);
    end
    return r;
  endfunction
endpackage

FILE: rtl/tbp_ifs.sv
// Channel interfaces: branch input, prediction result, configuration write.
`timescale 1ns / 1ps
interface tbp_branch_if;
  logic        valid;
  logic        ready;
  logic [31:0] branch_address;
  logic        taken;
  modport source (output valid, branch_address, taken, input ready);
  modport sink   (input valid, branch_address, taken, output ready);
endinterface

interface tbp_result_if;
  logic valid;
  logic ready;
  logic final_prediction;
  logic global_prediction;
  logic local_prediction;
  logic used_global;
  logic mispredict;
  modport source (output valid, final_prediction, global_prediction, local_prediction,
                  used_global, mispredict, input ready);
  modport sink   (input valid, final_prediction, global_prediction, local_prediction,
                  used_global, mispredict, output ready);
endinterface

interface tbp_cfg_if;
  logic       valid;
  logic       ready;
  logic [3:0] counter_bits;
  modport source (output valid, counter_bits, input ready);
  modport sink   (input valid, counter_bits, output ready);
endinterface

FILE: rtl/tbp_front.sv
// Front end: accepts branches, reduces the address and queues them.
`timescale 1ns / 1ps
module tbp_front (
  input  logic                     clk,
  input  logic                     rst,
  tbp_branch_if.sink               branch,
  input  tbp_pkg::back_stat_t      stat,
  output tbp_pkg::head_t           head
);
  tbp_pkg::item_t q [tbp_pkg::QUEUE_DEPTH];
  logic           wr_ptr;
  logic           rd_ptr;
  logic [1:0]     count;
  logic           push;

  assign branch.ready = (count != 2'(tbp_pkg::QUEUE_DEPTH)) && !stat.clearing;
  assign push = branch.valid && branch.ready;
  assign head.valid = (count != 2'd0);
  assign head.item  = q[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      q[wr_ptr].pc    <= branch.branch_address[tbp_pkg::INDEX_BITS-1:0];
      q[wr_ptr].taken <= branch.taken;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (stat.pop) rd_ptr <= ~rd_ptr;
      unique case ({push, stat.pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    stat.pop |-> head.valid) else $error("pop from empty queue");
  a_no_push_clear: assert property (@(posedge clk) disable iff (rst)
    stat.clearing |-> !push) else $error("push during clear");
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= 2'(tbp_pkg::QUEUE_DEPTH)) else $error("queue overflow");
`endif
endmodule

FILE: rtl/tbp_back.sv
// Back end: table lookups, prediction, result register and table updates.
`timescale 1ns / 1ps
module tbp_back (
  input  logic                 clk,
  input  logic                 rst,
  input  tbp_pkg::head_t       head,
  output tbp_pkg::back_stat_t  stat,
  tbp_result_if.source         result,
  tbp_cfg_if.sink              cfg
);
  tbp_pkg::ctr_t lc_mem [tbp_pkg::ENTRIES];
  tbp_pkg::ctr_t gs_mem [tbp_pkg::ENTRIES];
  tbp_pkg::idx_t lh_mem [tbp_pkg::ENTRIES];
  tbp_pkg::chs_t ch_mem [tbp_pkg::ENTRIES];

  tbp_pkg::back_state_t state, state_next;
  tbp_pkg::idx_t clr_idx;
  tbp_pkg::cfg_t counter_bits;
  tbp_pkg::idx_t ghist;
  tbp_pkg::item_t cur;
  tbp_pkg::idx_t gi;
  tbp_pkg::idx_t lh_rd;
  tbp_pkg::ctr_t lc_rd, gc_rd;
  tbp_pkg::chs_t ch_rd;

  logic issue, fire, out_free, clear_we;
  tbp_pkg::cfg_t bits;
  tbp_pkg::ctr_t maxv, thr, lc, gc;
  logic lp, gp, useg, fp, gok, lok;
  tbp_pkg::chs_t ch_new;

  assign cfg.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) counter_bits <= tbp_pkg::cfg_t'(2);
    else if (cfg.valid) counter_bits <= cfg.counter_bits;
  end

  assign out_free = !result.valid || result.ready;

  always_comb begin
    state_next = state;
    unique case (state)
      tbp_pkg::ST_CLEAR: if (clr_idx == '1) state_next = tbp_pkg::ST_IDLE;
      tbp_pkg::ST_IDLE:  if (head.valid) state_next = tbp_pkg::ST_HIST;
      tbp_pkg::ST_HIST:  state_next = tbp_pkg::ST_CALC;
      tbp_pkg::ST_CALC:  if (out_free) state_next = tbp_pkg::ST_IDLE;
      default:           state_next = tbp_pkg::ST_CLEAR;
    endcase
  end

  always_comb begin
    clear_we = (state == tbp_pkg::ST_CLEAR);
    issue    = (state == tbp_pkg::ST_IDLE) && head.valid;
    fire     = (state == tbp_pkg::ST_CALC) && out_free;
  end

  assign stat.pop      = issue;
  assign stat.clearing = clear_we;

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= tbp_pkg::ST_CLEAR;
      clr_idx <= '0;
      ghist   <= '0;
    end else begin
      state <= state_next;
      if (clear_we) clr_idx <= clr_idx + tbp_pkg::idx_t'(1);
      if (fire) ghist <= {ghist[tbp_pkg::INDEX_BITS-2:0], cur.taken};
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      cur <= head.item;
      gi  <= head.item.pc ^ ghist;
    end
  end

  // prediction math on the read data
  always_comb begin
    bits = tbp_pkg::eff_bits(counter_bits);
    maxv = tbp_pkg::max_val(bits);
    thr  = (maxv >> 1) + tbp_pkg::ctr_t'(1);
    lc   = (lc_rd > maxv) ? maxv : lc_rd;
    gc   = (gc_rd > maxv) ? maxv : gc_rd;
    lp   = lc >= thr;
    gp   = gc >= thr;
    useg = ch_rd >= tbp_pkg::CHS_GSHARE;
    fp   = useg ? gp : lp;
    gok  = gp == cur.taken;
    lok  = lp == cur.taken;
    ch_new = ch_rd;
    if (gok && !lok && ch_rd != tbp_pkg::CHS_MAX) ch_new = ch_rd + tbp_pkg::chs_t'(1);
    else if (lok && !gok && ch_rd != '0) ch_new = ch_rd - tbp_pkg::chs_t'(1);
  end

  // local history and chooser, indexed by pc
  always_ff @(posedge clk) begin
    if (clear_we) begin
      lh_mem[clr_idx] <= '0;
      ch_mem[clr_idx] <= '0;
    end else if (fire) begin
      lh_mem[cur.pc] <= {lh_rd[tbp_pkg::INDEX_BITS-2:0], cur.taken};
      ch_mem[cur.pc] <= ch_new;
    end
    if (issue) begin
      lh_rd <= lh_mem[head.item.pc];
      ch_rd <= ch_mem[head.item.pc];
    end
  end

  always_ff @(posedge clk) begin
    if (clear_we) gs_mem[clr_idx] <= '0;
    else if (fire) gs_mem[gi] <= tbp_pkg::bump(gc, maxv, cur.taken);
    if (issue) gc_rd <= gs_mem[head.item.pc ^ ghist];
  end

  always_ff @(posedge clk) begin
    if (clear_we) lc_mem[clr_idx] <= '0;
    else if (fire) lc_mem[lh_rd] <= tbp_pkg::bump(lc, maxv, cur.taken);
    if (state == tbp_pkg::ST_HIST) lc_rd <= lc_mem[lh_rd];
  end

  always_ff @(posedge clk) begin
    if (rst) result.valid <= 1'b0;
    else if (fire) result.valid <= 1'b1;
    else if (result.ready) result.valid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      result.final_prediction  <= fp;
      result.global_prediction <= gp;
      result.local_prediction  <= lp;
      result.used_global       <= useg;
      result.mispredict        <= fp ^ cur.taken;
    end
  end

`ifndef NO_ASSERTIONS
  a_final_sel: assert property (@(posedge clk) disable iff (rst)
    result.valid |-> result.final_prediction ==
      (result.used_global ? result.global_prediction : result.local_prediction))
    else $error("final prediction not the chosen one");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    result.valid && !result.ready |=> result.valid) else $error("result dropped");
  a_no_pop_clear: assert property (@(posedge clk) disable iff (rst)
    clear_we |-> !stat.pop) else $error("item taken during clear");
  a_fire_free: assert property (@(posedge clk) disable iff (rst)
    fire |-> out_free) else $error("result overwritten");
`endif
endmodule

FILE: rtl/tournament_branch_predictor_top.sv
// Top level of the tournament (local + gshare) branch predictor.
`timescale 1ns / 1ps
// Channel  | dir | transfer when       | payload
// branch   | in  | valid && ready      | branch_address[31:0], taken
// result   | out | valid && ready      | final/global/local_prediction, used_global, mispredict
// cfg      | in  | valid && ready      | counter_bits[3:0]
//
// Each branch goes through the back end in order: history/chooser/gshare read,
// local counter read (depends on the history), then predict and write back.
// After reset a clearing pass zeroes all tables; branch.ready stays low
// meanwhile, cfg is always ready.
// A 2-entry queue splits front and back; the result register holds one
// transfer, so the back end stalls only when a result is still unread.
module tournament_branch_predictor_top (
  input logic          clk,
  input logic          rst,
  tbp_branch_if.sink   branch,
  tbp_result_if.source result,
  tbp_cfg_if.sink      cfg
);
  tbp_pkg::head_t      head;
  tbp_pkg::back_stat_t stat;

  // accept and queue
  tbp_front u_front (
    .clk    (clk),
    .rst    (rst),
    .branch (branch),
    .stat   (stat),
    .head   (head)
  );

  // lookup, predict, update
  tbp_back u_back (
    .clk    (clk),
    .rst    (rst),
    .head   (head),
    .stat   (stat),
    .result (result),
    .cfg    (cfg)
  );
endmodule
